@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked through reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/hrls_pkg.sv @@
// Shared types and constants for the horizontal run smoothing block.
// No dependencies.
package hrls_pkg;

   localparam int PIX_W     = 8;
   localparam int LIMIT_W   = 6;
   // run counts and buffer addresses cover the full MAX_RUN range (1..63)
   localparam int RUN_CNT_W = 6;

   localparam logic [PIX_W-1:0] BIN_THRESHOLD = 8'd150;
   localparam logic [PIX_W-1:0] PIX_WHITE     = 8'd255;
   localparam logic [PIX_W-1:0] PIX_BLACK     = 8'd0;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = 2;
   localparam int CMD_CNT_W = 3;

   // one burst: count leading pixels (buffer or fill), then the base pixel
   typedef struct packed {
      logic [RUN_CNT_W-1:0] count;
      logic                 from_buf;
      logic                 fill_hi;
      logic                 base_hi;
      logic                 row_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
      logic has_buf;
   } q_status_type;

   function automatic logic [PIX_W-1:0] pix_of(input logic hi);
      return hi ? PIX_WHITE : PIX_BLACK;
   endfunction

endpackage

@@ rtl/core/hrls_run_mem.sv @@
// Run buffer: one-bit base pixels of the held run, one write and one
// registered read port. Depends on hrls_pkg.
module hrls_run_mem #(
   parameter int DEPTH = 63
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [hrls_pkg::RUN_CNT_W-1:0] wr_addr,
   input  logic                          wr_data,
   input  logic                          rd_en,
   input  logic [hrls_pkg::RUN_CNT_W-1:0] rd_addr,
   output logic                          rd_data
);
   import hrls_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[ADDR_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/hrls_cmd_queue.sv @@
// Burst command queue between front and back end.
// Depends on hrls_pkg.
module hrls_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hrls_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output hrls_pkg::cmd_type      head,
   output hrls_pkg::q_status_type status
);
   import hrls_pkg::*;

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic [CMD_CNT_W-1:0] buf_cnt_ff, buf_cnt_in;

   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
      // buffer-reading commands still queued; the front holds off buffer writes
      buf_cnt_in = buf_cnt_ff + CMD_CNT_W'(push && push_cmd.from_buf)
                              - CMD_CNT_W'(pop && head.from_buf);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         buf_cnt_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
         buf_cnt_ff <= buf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign status.full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign status.valid   = (count_ff != '0);
   assign status.has_buf = (buf_cnt_ff != '0);

endmodule

@@ rtl/core/hrls_front.sv @@
// Front end: binarizes, tracks run and row state, writes held pixels to
// the run buffer and queues burst commands. Depends on hrls_pkg.
module hrls_front #(
   parameter int MAX_RUN = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hrls_pkg::PIX_W-1:0]     req_in_pixel,
   input  logic [hrls_pkg::PIX_W-1:0]     req_base_pixel,
   input  logic [hrls_pkg::LIMIT_W-1:0]   req_row_run_limit,
   input  logic                           req_row_end,
   input  hrls_pkg::q_status_type         q_status,
   output logic                           push,
   output hrls_pkg::cmd_type              push_cmd,
   output logic                           mem_wr_en,
   output logic [hrls_pkg::RUN_CNT_W-1:0] mem_wr_addr,
   output logic                           mem_wr_data
);
   import hrls_pkg::*;

   localparam logic [LIMIT_W-1:0]   LIMIT_MAX = LIMIT_W'(MAX_RUN);
   localparam logic [RUN_CNT_W-1:0] LEN_MAX   = RUN_CNT_W'(MAX_RUN);

   logic                 run_color_ff;
   logic [RUN_CNT_W-1:0] len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 row_start_ff, row_start_in;

   logic                 src_hi, base_hi, in_run, hold, accept;
   logic [LIMIT_W-1:0]   lim_sat, lim_eff;

   always_comb begin
      src_hi  = (req_in_pixel > BIN_THRESHOLD);
      base_hi = (req_base_pixel > BIN_THRESHOLD);
      in_run  = (src_hi == run_color_ff);
      lim_sat = (req_row_run_limit > LIMIT_MAX) ? LIMIT_MAX : req_row_run_limit;
      lim_eff = row_start_ff ? lim_sat : limit_ff;
      hold    = in_run && !ovf_ff && !req_row_end
                && (len_ff < RUN_CNT_W'(lim_eff)) && (len_ff < LEN_MAX);
   end

   // held pixels must not overwrite a buffer still being read out
   assign req_stall = hold ? q_status.has_buf : q_status.full;
   assign accept    = req_valid && !req_stall;

   assign push              = accept && !hold;
   assign push_cmd.count    = len_ff;
   assign push_cmd.from_buf = in_run && (len_ff != '0);
   assign push_cmd.fill_hi  = !run_color_ff;
   assign push_cmd.base_hi  = base_hi;
   assign push_cmd.row_end  = req_row_end;

   assign mem_wr_en   = accept && hold;
   assign mem_wr_addr = len_ff;
   assign mem_wr_data = base_hi;

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      limit_in     = limit_ff;
      row_start_in = row_start_ff;
      if (accept) begin
         limit_in     = lim_eff;
         row_start_in = req_row_end;
         priority if (req_row_end) begin
            len_in = '0;
            ovf_in = 1'b0;
         end else if (hold) begin
            len_in = len_ff + 1'b1;
         end else begin
            len_in = '0;
            ovf_in = in_run;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_color_ff <= 1'b0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         limit_ff     <= '0;
         row_start_ff <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            run_color_ff <= csr_wr_data;
         end
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         limit_ff     <= limit_in;
         row_start_ff <= row_start_in;
      end
   end

endmodule

@@ rtl/core/hrls_back.sv @@
// Back end: expands queued commands into result pixels through a read
// stage and an output register. Depends on hrls_pkg.
module hrls_back (
   input  logic                           clock,
   input  logic                           reset,
   input  hrls_pkg::cmd_type              head,
   input  hrls_pkg::q_status_type         q_status,
   output logic                           pop,
   output logic                           mem_rd_en,
   output logic [hrls_pkg::RUN_CNT_W-1:0] mem_rd_addr,
   input  logic                           mem_rd_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hrls_pkg::PIX_W-1:0]     rsp_out_pixel,
   output logic                           rsp_out_row_end,
   output logic                           rsp_burst_last
);
   import hrls_pkg::*;

   logic [RUN_CNT_W-1:0] idx_ff, idx_in;
   logic                 p_valid_ff, p_valid_in;
   logic                 p_from_mem_ff, p_hi_ff, p_row_end_ff, p_last_ff;
   logic                 o_valid_ff, o_valid_in;
   logic [PIX_W-1:0]     o_pixel_ff;
   logic                 o_row_end_ff, o_last_ff;

   logic o_free, p_ready, issue, tail;

   always_comb begin
      o_free     = !o_valid_ff || !rsp_stall;
      p_ready    = !p_valid_ff || o_free;
      issue      = q_status.valid && p_ready;
      tail       = (idx_ff == head.count);
      p_valid_in = p_ready ? issue : p_valid_ff;
      o_valid_in = o_free ? p_valid_ff : o_valid_ff;
      idx_in     = idx_ff;
      if (issue) begin
         idx_in = tail ? '0 : idx_ff + 1'b1;
      end
   end

   assign pop         = issue && tail;
   assign mem_rd_en   = issue && !tail && head.from_buf;
   assign mem_rd_addr = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p_from_mem_ff <= !tail && head.from_buf;
         p_hi_ff       <= tail ? head.base_hi : head.fill_hi;
         p_row_end_ff  <= tail && head.row_end;
         p_last_ff     <= tail;
      end
      if (o_free && p_valid_ff) begin
         o_pixel_ff   <= pix_of(p_from_mem_ff ? mem_rd_data : p_hi_ff);
         o_row_end_ff <= p_row_end_ff;
         o_last_ff    <= p_last_ff;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_out_pixel   = o_pixel_ff;
   assign rsp_out_row_end = o_row_end_ff;
   assign rsp_burst_last  = o_last_ff;

endmodule

@@ rtl/core/horizontal_run_length_smoothing.sv @@
// Horizontal run smoothing, top level. Depends on hrls_pkg and the hrls_ modules.
// A result leaves the command queue, the read stage and the output register in turn.
// Throughput: one result per cycle while rsp_stall is low; a transaction yields 0 to
//   MAX_RUN+1 results, about one per input on average. Held-run inputs stall only
//   while a buffer readout is still queued; others stall only on a full queue.
// Reset: synchronous, active high; clears run/row state, queue and valids. No clear pass.
module horizontal_run_length_smoothing #(
   parameter int MAX_RUN = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration: run color
   input  logic                            csr_wr_en,
   input  logic                            csr_wr_data,
   // input pixel transactions
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hrls_pkg::PIX_W-1:0]      req_in_pixel,
   input  logic [hrls_pkg::PIX_W-1:0]      req_base_pixel,
   input  logic [hrls_pkg::LIMIT_W-1:0]    req_row_run_limit,
   input  logic                            req_row_end,
   // result pixel transactions
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hrls_pkg::PIX_W-1:0]      rsp_out_pixel,
   output logic                            rsp_out_row_end,
   output logic                            rsp_burst_last
);
   import hrls_pkg::*;

   // front to queue
   logic                 push;
   cmd_type              push_cmd;
   // queue to back
   cmd_type              head;
   q_status_type         q_status;
   logic                 pop;
   // run buffer ports
   logic                 mem_wr_en, mem_wr_data;
   logic [RUN_CNT_W-1:0] mem_wr_addr;
   logic                 mem_rd_en, mem_rd_data;
   logic [RUN_CNT_W-1:0] mem_rd_addr;

   // Front: classifies each pixel against the run color. Run pixels within
   // the row limit are parked in the run buffer; everything else turns into
   // one burst command (leading count + the pixel's own base value).
   hrls_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_pixel      (req_in_pixel),
      .req_base_pixel    (req_base_pixel),
      .req_row_run_limit (req_row_run_limit),
      .req_row_end       (req_row_end),
      .q_status          (q_status),
      .push              (push),
      .push_cmd          (push_cmd),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data)
   );

   // Short command queue decouples the two sides.
   hrls_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // Held base pixels of the open run; read back for unfilled flushes.
   hrls_run_mem #(
      .DEPTH (MAX_RUN)
   ) u_run_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Back: plays out commands one pixel per cycle unless stalled; burst_last on tail.
   hrls_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_pixel   (rsp_out_pixel),
      .rsp_out_row_end (rsp_out_row_end),
      .rsp_burst_last  (rsp_burst_last)
   );

endmodule

@@ rtl/core/hrls_checker.sv @@
// Port-level checks for the run smoothing top level, bound to it below.
// Depends on hrls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hrls_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [hrls_pkg::PIX_W-1:0]   rsp_out_pixel,
   input logic                         rsp_out_row_end,
   input logic                         rsp_burst_last
);
   import hrls_pkg::*;

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pixel)
         && $stable(rsp_out_row_end) && $stable(rsp_burst_last),
      "stalled result changed")
   `ASSERT_CLK_RST(a_pix_binary, clock, reset,
      rsp_valid |-> (rsp_out_pixel == PIX_WHITE || rsp_out_pixel == PIX_BLACK),
      "result pixel not binary")
   `ASSERT_CLK_RST(a_row_end_last, clock, reset,
      rsp_valid && rsp_out_row_end |-> rsp_burst_last,
      "row end inside a burst")
   `ASSERT_CLK_RST(a_burst_gapless, clock, reset,
      rsp_valid && !rsp_stall && !rsp_burst_last |=> rsp_valid,
      "gap inside a burst")
   `ASSERT_CLK(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind horizontal_run_length_smoothing hrls_checker u_hrls_checker (.*);

@@ test/horizontal_run_length_smoothing_check.sv @@
`timescale 1ns / 1ps
// Result checker for horizontal_run_length_smoothing: watches both pixel channels
// and the run color port. Depends on hrls_pkg for widths and pixel constants.
module horizontal_run_length_smoothing_check #(
   parameter int MAX_RUN = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [hrls_pkg::PIX_W-1:0]   req_in_pixel,
   input  logic [hrls_pkg::PIX_W-1:0]   req_base_pixel,
   input  logic [hrls_pkg::LIMIT_W-1:0] req_row_run_limit,
   input  logic                         req_row_end,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [hrls_pkg::PIX_W-1:0]   rsp_out_pixel,
   input  logic                         rsp_out_row_end,
   input  logic                         rsp_burst_last,
   output int                           error_count,
   output int                           pending
);
   import hrls_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
      logic             last;
   } out_px_type;

   out_px_type       future_px[$];

   // smoothing state
   logic [MAX_RUN-1:0] held_base;
   int                 held_count;
   logic               run_spilled;
   int                 row_limit;
   logic               row_start;
   logic               white_runs;

   function automatic logic [PIX_W-1:0] threshold(input logic [PIX_W-1:0] v);
      return (v > BIN_THRESHOLD) ? PIX_WHITE : PIX_BLACK;
   endfunction

   task automatic queue_px(input logic [PIX_W-1:0] p, input logic re);
      out_px_type e;
      e.pixel   = p;
      e.row_end = re;
      e.last    = 1'b0;
      future_px.push_back(e);
   endtask

   task automatic smooth_pixel(input logic [PIX_W-1:0] src_raw,
                               input logic [PIX_W-1:0] base_raw,
                               input logic [LIMIT_W-1:0] lim,
                               input logic re);
      logic [PIX_W-1:0] src;
      logic [PIX_W-1:0] base;
      logic             in_run;
      int               first;
      int               i;
      first  = future_px.size();
      src    = threshold(src_raw);
      base   = threshold(base_raw);
      in_run = ((src == PIX_WHITE) == white_runs);
      if (row_start) begin
         row_limit = (int'(lim) > MAX_RUN) ? MAX_RUN : int'(lim);
         row_start = 1'b0;
      end
      if (in_run) begin
         if (run_spilled) begin
            queue_px(base, re);
         end else if (!re && held_count < row_limit && held_count < MAX_RUN) begin
            held_base[held_count] = base[0];
            held_count++;
         end else begin
            // run too long (or row closes): held pixels go out unfilled
            for (i = 0; i < held_count; i++)
               queue_px(held_base[i] ? PIX_WHITE : PIX_BLACK, 1'b0);
            held_count = 0;
            queue_px(base, re);
            if (!re) run_spilled = 1'b1;
         end
      end else begin
         if (!run_spilled && held_count > 0)
            for (i = 0; i < held_count; i++)
               queue_px(white_runs ? PIX_BLACK : PIX_WHITE, 1'b0);
         held_count  = 0;
         run_spilled = 1'b0;
         queue_px(base, re);
      end
      if (re) begin
         held_count  = 0;
         run_spilled = 1'b0;
         row_start   = 1'b1;
      end
      if (future_px.size() > first)
         future_px[$].last = 1'b1;
   endtask

   task automatic compare_px();
      out_px_type e;
      if (future_px.size() == 0) begin
         $display("%0t: unexpected result pixel %0d row_end %0b last %0b", $time,
                  rsp_out_pixel, rsp_out_row_end, rsp_burst_last);
         error_count++;
      end else begin
         e = future_px.pop_front();
         if (rsp_out_pixel !== e.pixel) begin
            $display("%0t: out_pixel expected %0d actual %0d", $time, e.pixel, rsp_out_pixel);
            error_count++;
         end
         if (rsp_out_row_end !== e.row_end) begin
            $display("%0t: out_row_end expected %0b actual %0b", $time, e.row_end,
                     rsp_out_row_end);
            error_count++;
         end
         if (rsp_burst_last !== e.last) begin
            $display("%0t: burst_last expected %0b actual %0b", $time, e.last, rsp_burst_last);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         future_px.delete();
         error_count = 0;
         held_base   = '0;
         held_count  = 0;
         run_spilled = 1'b0;
         row_limit   = 0;
         row_start   = 1'b1;
         white_runs  = 1'b0;
      end else begin
         // results first: a transaction accepted now cannot be answered on the same edge
         if (rsp_valid && !rsp_stall) compare_px();
         if (req_valid && !req_stall)
            smooth_pixel(req_in_pixel, req_base_pixel, req_row_run_limit, req_row_end);
         // a color written on this edge applies from the next transaction on
         if (csr_wr_en) white_runs = csr_wr_data;
      end
      pending = future_px.size();
   end

endmodule

@@ test/horizontal_run_length_smoothing_test.sv @@
`timescale 1ns / 1ps
// Top of the horizontal_run_length_smoothing testbench: clock, reset, stimulus and verdict.
// Depends on hrls_pkg, the block and horizontal_run_length_smoothing_check.
module horizontal_run_length_smoothing_test;
   import hrls_pkg::*;

   localparam int  MAX_RUN        = 63;
   localparam int  SETTLE_CYCLES  = 10;    // a held pixel yields nothing
   localparam int  WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either side

   // run color register values
   localparam logic BLACK_RUNS = 1'b0;     // black runs filled white
   localparam logic WHITE_RUNS = 1'b1;     // white runs filled black

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic                 csr_wr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_in_pixel;
   logic [PIX_W-1:0]     req_base_pixel;
   logic [LIMIT_W-1:0]   req_row_run_limit;
   logic                 req_row_end;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIX_W-1:0]     rsp_out_pixel;
   logic                 rsp_out_row_end;
   logic                 rsp_burst_last;

   int   error_count;
   int   pending;
   int   pixels_sent = 0;
   logic run_light;        // color of the runs the block currently holds
   logic steady = 1'b0;    // no gaps and no new receiver stalls while set
   int   stall_left = 0;
   int   stall_pick;
   int   quiet_cycles = 0;

   always #6 clock = ~clock;

   horizontal_run_length_smoothing #(
      .MAX_RUN(MAX_RUN)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_pixel      (req_in_pixel),
      .req_base_pixel    (req_base_pixel),
      .req_row_run_limit (req_row_run_limit),
      .req_row_end       (req_row_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_out_row_end   (rsp_out_row_end),
      .rsp_burst_last    (rsp_burst_last)
   );

   horizontal_run_length_smoothing_check #(
      .MAX_RUN(MAX_RUN)
   ) pixel_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_pixel      (req_in_pixel),
      .req_base_pixel    (req_base_pixel),
      .req_row_run_limit (req_row_run_limit),
      .req_row_end       (req_row_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_out_row_end   (rsp_out_row_end),
      .rsp_burst_last    (rsp_burst_last),
      .error_count       (error_count),
      .pending           (pending)
   );

   // Receiver back-pressure: spells of ready and stall, mostly short, a few long.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 50) begin
            rsp_stall  <= 1'b0;
            stall_left = $urandom_range(0, 5);
         end else if (stall_pick < 92) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(15, 60);
         end
      end
   end

   // Watchdog: a run of cycles with no transaction anywhere means the block hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int gap_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One input transaction; returns once the block has taken it. Valid stays high
   // so a following transaction with no gap goes out back to back.
   task automatic send_px(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] base,
                          input logic [LIMIT_W-1:0] lim, input logic re);
      int gap;
      gap = steady ? 0 : gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_pixel      <= src;
      req_base_pixel    <= base;
      req_row_run_limit <= lim;
      req_row_end       <= re;
      // taken at the first edge that sees stall low
      @(posedge clock iff !req_stall);
      pixels_sent++;
   endtask

   // Sender holds off until every expected result is out, then lets the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_run_color(input logic color);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= color;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      run_light   = color;
   endtask

   function automatic logic [PIX_W-1:0] shade(input logic light);
      return light ? PIX_W'($urandom_range(151, 255)) : PIX_W'($urandom_range(0, 150));
   endfunction

   // Well-formed row: alternating color segments sized around the row limit, so
   // runs get filled, spill over the limit, and stay open at the row end.
   task automatic structured_row();
      int   len;
      int   lim;
      int   seg;
      int   k;
      logic light;
      lim   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      light = 1'($urandom_range(0, 1));
      k     = 0;
      while (k < len) begin
         seg = $urandom_range(1, lim + 2);
         while (seg > 0 && k < len) begin
            // only the first pixel's limit counts; the rest carry random limits
            send_px(shade(light), PIX_W'($urandom()),
                    (k == 0) ? LIMIT_W'(lim) : LIMIT_W'($urandom_range(0, 63)),
                    k == len - 1);
            seg--;
            k++;
         end
         light = ~light;
      end
   endtask

   // Noise: any value in every field, row ends at random.
   task automatic noise_row();
      int len;
      int k;
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++)
         send_px(PIX_W'($urandom()), PIX_W'($urandom()), LIMIT_W'($urandom_range(0, 63)),
                 (k == len - 1) || ($urandom_range(0, 3) == 0));
   endtask

   // A run of the held color at the full limit, closed by the other color.
   task automatic long_run_row(input int run_len);
      int k;
      for (k = 0; k < run_len; k++)
         send_px(shade(run_light), PIX_W'($urandom()), LIMIT_W'(MAX_RUN), 1'b0);
      send_px(shade(~run_light), PIX_W'($urandom()), LIMIT_W'($urandom_range(0, 63)), 1'b1);
   endtask

   task automatic random_rows(input int count);
      int stop;
      stop = pixels_sent + count;
      while (pixels_sent < stop) begin
         if ($urandom_range(0, 99) < 80)
            structured_row();
         else
            noise_row();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= 1'b0;
      req_valid         <= 1'b0;
      req_in_pixel      <= '0;
      req_base_pixel    <= '0;
      req_row_run_limit <= '0;
      req_row_end       <= 1'b0;
      run_light         = BLACK_RUNS;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: black runs, filled white ----
      set_run_color(BLACK_RUNS);
      // single-pixel rows, held color and other color
      send_px(8'd0, 8'd255, 6'd5, 1'b1);
      send_px(8'd255, 8'd0, 6'd0, 1'b1);
      // limit 2: threshold edges, a filled run, a spilled run, an open run at row end
      send_px(8'd151, 8'd150, 6'd2, 1'b0);
      send_px(8'd150, 8'd151, 6'd63, 1'b0);
      send_px(8'd0, 8'd255, 6'd0, 1'b0);
      send_px(8'd200, 8'd0, 6'd0, 1'b0);     // fills the two held pixels
      send_px(8'd10, 8'd255, 6'd1, 1'b0);
      send_px(8'd20, 8'd0, 6'd1, 1'b0);
      send_px(8'd30, 8'd255, 6'd1, 1'b0);    // over the limit: held pixels spill
      send_px(8'd40, 8'd0, 6'd1, 1'b0);      // streams straight through
      send_px(8'd255, 8'd255, 6'd1, 1'b0);
      send_px(8'd0, 8'd0, 6'd1, 1'b0);
      send_px(8'd1, 8'd255, 6'd1, 1'b1);     // run open at row end goes out unfilled
      // limit zero: nothing is ever held
      send_px(8'd0, 8'd255, 6'd0, 1'b0);
      send_px(8'd0, 8'd0, 6'd17, 1'b0);
      send_px(8'd255, 8'd151, 6'd42, 1'b1);
      // top limit, short row
      send_px(8'd100, 8'd200, 6'd63, 1'b0);
      send_px(8'd100, 8'd100, 6'd0, 1'b0);
      send_px(8'd160, 8'd255, 6'd0, 1'b1);
      drain();

      // ---- random: white runs, gaps and stalls ----
      set_run_color(WHITE_RUNS);
      random_rows(25);
      drain();

      // ---- random: black runs, back to back with no idling ----
      set_run_color(BLACK_RUNS);
      steady = 1'b1;
      random_rows(25);
      drain();
      steady = 1'b0;

      // ---- random: white runs, plus the largest burst ----
      set_run_color(WHITE_RUNS);
      random_rows(10);
      long_run_row(MAX_RUN + 1);    // full buffer held, then spilled unfilled
      drain();

      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
